[src/fed_pkg.sv]
// Shared constants and types for the feedback echo with fractional delay.
// Used by the top level and its port checker; no dependencies.
package fed_pkg;

    localparam int HISTORY_DEPTH_DEF = 131072;
    localparam int SAMPLE_W          = 24;
    localparam int FRAC_W            = 24;
    localparam int TARGET_W          = 25;
    localparam int GAIN_W            = 17;
    localparam int CFG_ADDR_W        = 4;
    localparam int CFG_DATA_W        = 32;

    localparam logic [GAIN_W-1:0]   GAIN_ONE   = 17'd65536;
    localparam int                  GLIDE_COEF = 16777;   // 0.001 in Q0.24

    localparam logic [TARGET_W-1:0] TARGET_RESET   = 25'd3686400;
    localparam logic [GAIN_W-1:0]   FEEDBACK_RESET = 17'd26214;
    localparam logic [GAIN_W-1:0]   MIX_RESET      = 17'd22938;

    typedef logic [1:0] reg_idx_t;

    localparam reg_idx_t REG_TARGET_DELAY  = 2'd0;
    localparam reg_idx_t REG_FEEDBACK_GAIN = 2'd1;
    localparam reg_idx_t REG_MIX_GAIN      = 2'd2;

endpackage

[src/fed_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module fed_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 131072
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[src/feedback_echo_fractional_delay_top.sv]
// Feedback echo with gliding fractional delay and linear interpolation; uses fed_pkg, fed_ram.
// After the input is taken the states STEP, POS, ADDR, RDB, INTERP, WET, MIXW, FB and WR follow;
// WR loads the output register. One sample is in work at a time, with two reads on the single
// RAM port and one shared 25x25 multiplier; a result not yet taken holds WR until the output frees.
// Reset (synchronous, aresetn low) clears control, write pointer and glide delay; the history
// RAM is not swept: a wrap flag with the write pointer makes never-written entries read as zero.
module feedback_echo_fractional_delay_top
    import fed_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [SAMPLE_W-1:0]   s_tdata,   // [23:0] sample_in
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [SAMPLE_W-1:0]   m_tdata,   // [23:0] sample_out
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int GW = AW + FRAC_W;
    localparam int PW = 2 * (SAMPLE_W + 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_STEP   = 4'd1;
    localparam logic [3:0] S_POS    = 4'd2;
    localparam logic [3:0] S_ADDR   = 4'd3;
    localparam logic [3:0] S_RDB    = 4'd4;
    localparam logic [3:0] S_INTERP = 4'd5;
    localparam logic [3:0] S_WET    = 4'd6;
    localparam logic [3:0] S_MIXW   = 4'd7;
    localparam logic [3:0] S_FB     = 4'd8;
    localparam logic [3:0] S_WR     = 4'd9;

    localparam logic [32:0]           TargetLimit = 33'(HISTORY_DEPTH - 1) << 8;
    localparam logic [GW-1:0]         TargetMax   = GW'(HISTORY_DEPTH - 2) << FRAC_W;
    localparam logic signed [GW+15:0] GlideCoefS  = (GW+16)'(GLIDE_COEF);
    localparam logic signed [GW+15:0] RoundStep   = (GW+16)'(1) <<< (FRAC_W - 1);
    localparam logic signed [PW-1:0]  RoundHalf24 = PW'(1) <<< (FRAC_W - 1);
    localparam logic signed [PW-1:0]  RoundHalf16 = PW'(1) <<< 15;
    localparam logic signed [PW-1:0]  SampleMax   = PW'(8388607);
    localparam logic signed [PW-1:0]  SampleMin   = -PW'(8388608);
    localparam logic [AW-1:0]         LastIndex   = AW'(HISTORY_DEPTH - 1);

    function automatic logic [SAMPLE_W-1:0] sat_sample(input logic signed [PW-1:0] v);
        if (v > SampleMax) begin
            return SampleMax[SAMPLE_W-1:0];
        end else if (v < SampleMin) begin
            return SampleMin[SAMPLE_W-1:0];
        end
        return v[SAMPLE_W-1:0];
    endfunction

    // registers
    logic [3:0]                 state_reg, state_next;
    logic [TARGET_W-1:0]        cfg_target_reg, cfg_target_next;
    logic [GAIN_W-1:0]          cfg_fb_reg, cfg_fb_next;
    logic [GAIN_W-1:0]          cfg_mix_reg, cfg_mix_next;
    logic [AW-1:0]              wp_reg, wp_next;
    logic                       wrapped_reg, wrapped_next;
    logic [GW-1:0]              glide_reg, glide_next;
    logic signed [GW+15:0]      step_reg, step_next;
    logic [AW-1:0]              i0_reg, i0_next;
    logic [AW-1:0]              i1_reg, i1_next;
    logic [FRAC_W-1:0]          frac_reg, frac_next;
    logic signed [SAMPLE_W-1:0] dry_reg, dry_next;
    logic signed [SAMPLE_W-1:0] a_reg, a_next;
    logic signed [SAMPLE_W-1:0] wet_reg, wet_next;
    logic signed [PW-1:0]       prod_reg, prod_next;
    logic signed [PW-1:0]       acc_reg, acc_next;
    logic [SAMPLE_W-1:0]        result_reg, result_next;
    logic                       m_tvalid_reg, m_tvalid_next;
    logic [SAMPLE_W-1:0]        m_tdata_reg, m_tdata_next;

    // datapath
    logic [GAIN_W-1:0]          fb_eff, mix_eff, mix_inv;
    logic [GW-1:0]              target_w;
    logic signed [GW:0]         glide_diff;
    logic signed [GW+15:0]      step_w, step_rnd;
    logic signed [GW:0]         glide_sum;
    logic [AW+1:0]              ipos_w;
    logic [AW-1:0]              i0_w, i1_w;
    logic [FRAC_W-1:0]          frac_w;
    logic                       valid_i0, valid_i1;
    logic signed [SAMPLE_W-1:0] b_w;
    logic signed [SAMPLE_W:0]   diff_ab;
    logic signed [SAMPLE_W+1:0] interp_w, wet_full;
    logic signed [SAMPLE_W:0]   mul_a, mul_b;
    logic signed [PW-1:0]       product_w, mixed_w, out_rnd, fb_rnd, stored_sum;
    logic                       out_free;

    logic                       ram_we;
    logic [AW-1:0]              ram_raddr;
    logic [SAMPLE_W-1:0]        ram_rdata;
    logic [SAMPLE_W-1:0]        ram_wdata;

    fed_ram #(
        .WIDTH(SAMPLE_W),
        .DEPTH(HISTORY_DEPTH)
    ) u_hist_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(wp_reg),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // gains above one act as one
    assign fb_eff  = cfg_fb_reg[GAIN_W-1]  ? GAIN_ONE : cfg_fb_reg;
    assign mix_eff = cfg_mix_reg[GAIN_W-1] ? GAIN_ONE : cfg_mix_reg;
    assign mix_inv = GAIN_ONE - mix_eff;

    assign target_w = ({8'd0, cfg_target_reg} >= TargetLimit) ? TargetMax
                                                               : GW'({cfg_target_reg, 16'd0});

    assign glide_diff = $signed({1'b0, target_w}) - $signed({1'b0, glide_reg});
    assign step_w     = (GW+16)'(glide_diff) * GlideCoefS;
    assign step_rnd   = (step_reg + RoundStep) >>> FRAC_W;
    assign glide_sum  = $signed({1'b0, glide_reg}) + (GW+1)'(step_rnd);

    // read position: write pointer minus glide delay, wrapped once
    assign frac_w = FRAC_W'(0) - glide_reg[FRAC_W-1:0];
    assign ipos_w = (AW+2)'(wp_reg) - (AW+2)'(glide_reg[GW-1:FRAC_W])
                    - (AW+2)'(|glide_reg[FRAC_W-1:0]);
    assign i0_w   = ipos_w[AW+1] ? AW'(ipos_w + (AW+2)'(HISTORY_DEPTH)) : ipos_w[AW-1:0];
    assign i1_w   = (i0_reg == LastIndex) ? '0 : i0_reg + AW'(1);

    // entries ahead of the write pointer on the first lap were never written
    assign valid_i0 = wrapped_reg || (i0_reg < wp_reg);
    assign valid_i1 = wrapped_reg || (i1_reg < wp_reg);
    assign b_w      = valid_i1 ? $signed(ram_rdata) : '0;
    assign diff_ab  = (SAMPLE_W+1)'(b_w) - (SAMPLE_W+1)'(a_reg);

    assign interp_w  = (SAMPLE_W+2)'((prod_reg + RoundHalf24) >>> FRAC_W);
    assign wet_full  = (SAMPLE_W+2)'(a_reg) + interp_w;

    assign product_w  = mul_a * mul_b;
    assign mixed_w    = acc_reg + prod_reg;
    assign out_rnd    = (mixed_w + RoundHalf16) >>> 16;
    assign fb_rnd     = (prod_reg + RoundHalf16) >>> 16;
    assign stored_sum = PW'(dry_reg) + fb_rnd;
    assign ram_wdata  = sat_sample(stored_sum);

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next      = state_reg;
        cfg_target_next = cfg_target_reg;
        cfg_fb_next     = cfg_fb_reg;
        cfg_mix_next    = cfg_mix_reg;
        wp_next         = wp_reg;
        wrapped_next    = wrapped_reg;
        glide_next      = glide_reg;
        step_next       = step_reg;
        i0_next         = i0_reg;
        i1_next         = i1_reg;
        frac_next       = frac_reg;
        dry_next        = dry_reg;
        a_next          = a_reg;
        wet_next        = wet_reg;
        prod_next       = prod_reg;
        acc_next        = acc_reg;
        result_next     = result_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        ram_we          = 1'b0;
        ram_raddr       = i0_w;
        mul_a           = '0;
        mul_b           = '0;

        if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                REG_TARGET_DELAY:  cfg_target_next = pwdata[TARGET_W-1:0];
                REG_FEEDBACK_GAIN: cfg_fb_next     = pwdata[GAIN_W-1:0];
                REG_MIX_GAIN:      cfg_mix_next    = pwdata[GAIN_W-1:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    dry_next   = $signed(s_tdata);
                    // snap to the target while the delay is still zero
                    glide_next = (glide_reg == '0) ? target_w : glide_reg;
                    state_next = S_STEP;
                end
            end
            S_STEP: begin
                step_next  = step_w;
                state_next = S_POS;
            end
            S_POS: begin
                glide_next = glide_sum[GW-1:0];
                state_next = S_ADDR;
            end
            S_ADDR: begin
                ram_raddr  = i0_w;
                i0_next    = i0_w;
                frac_next  = frac_w;
                state_next = S_RDB;
            end
            S_RDB: begin
                ram_raddr  = i1_w;
                i1_next    = i1_w;
                a_next     = valid_i0 ? $signed(ram_rdata) : '0;
                state_next = S_INTERP;
            end
            S_INTERP: begin
                mul_a      = diff_ab;
                mul_b      = $signed({1'b0, frac_reg});
                prod_next  = product_w;
                state_next = S_WET;
            end
            S_WET: begin
                wet_next   = wet_full[SAMPLE_W-1:0];
                mul_a      = (SAMPLE_W+1)'(dry_reg);
                mul_b      = $signed((SAMPLE_W+1)'(mix_inv));
                prod_next  = product_w;
                state_next = S_MIXW;
            end
            S_MIXW: begin
                acc_next   = prod_reg;
                mul_a      = (SAMPLE_W+1)'(wet_reg);
                mul_b      = $signed((SAMPLE_W+1)'(mix_eff));
                prod_next  = product_w;
                state_next = S_FB;
            end
            S_FB: begin
                result_next = sat_sample(out_rnd);
                mul_a       = (SAMPLE_W+1)'(wet_reg);
                mul_b       = $signed((SAMPLE_W+1)'(fb_eff));
                prod_next   = product_w;
                state_next  = S_WR;
            end
            S_WR: begin
                // hold until the output register can take the result
                if (out_free) begin
                    ram_we        = 1'b1;
                    wp_next       = (wp_reg == LastIndex) ? '0 : wp_reg + AW'(1);
                    wrapped_next  = wrapped_reg || (wp_reg == LastIndex);
                    m_tdata_next  = result_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            cfg_target_reg <= TARGET_RESET;
            cfg_fb_reg     <= FEEDBACK_RESET;
            cfg_mix_reg    <= MIX_RESET;
            wp_reg         <= '0;
            wrapped_reg    <= 1'b0;
            glide_reg      <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cfg_target_reg <= cfg_target_next;
            cfg_fb_reg     <= cfg_fb_next;
            cfg_mix_reg    <= cfg_mix_next;
            wp_reg         <= wp_next;
            wrapped_reg    <= wrapped_next;
            glide_reg      <= glide_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        step_reg    <= step_next;
        i0_reg      <= i0_next;
        i1_reg      <= i1_next;
        frac_reg    <= frac_next;
        dry_reg     <= dry_next;
        a_reg       <= a_next;
        wet_reg     <= wet_next;
        prod_reg    <= prod_next;
        acc_reg     <= acc_next;
        result_reg  <= result_next;
        m_tdata_reg <= m_tdata_next;
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_TARGET_DELAY:  prdata = CFG_DATA_W'(cfg_target_reg);
            REG_FEEDBACK_GAIN: prdata = CFG_DATA_W'(cfg_fb_reg);
            REG_MIX_GAIN:      prdata = CFG_DATA_W'(cfg_mix_reg);
            default:           prdata = '0;
        endcase
    end

    assign pready   = 1'b1;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

[src/fed_checker.sv]
// Port-level checker for the feedback echo top level, bound to it below.
// Depends on fed_pkg.
module fed_checker
    import fed_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [SAMPLE_W-1:0] m_tdata
);

    // one sample in flight: no second transaction right after one
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a sample is still in work");

    // a new result appears only as the block returns to idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> s_tready)
        else $error("result presented while the block is busy");

    // stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result dropped or changed");

    // reset leaves the block idle with no result pending
    assert property (@(posedge aclk)
        !aresetn |=> s_tready && !m_tvalid)
        else $error("block not idle after reset");

endmodule

bind feedback_echo_fractional_delay_top fed_checker u_fed_checker (.*);
